/* rtl/core/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// Command/response word layouts, datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // action codes
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // control bytes
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_FF    = 8'h0C;
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_LAST  = 8'h7F;

  localparam logic [7:0] RESET_ATTR = 8'h0F;

  typedef struct packed {
    logic        action;
    logic [7:0]  char_byte;
    logic [10:0] cell_index;
  } cmd_word_t;

  typedef struct packed {
    logic [10:0] cursor_index;
    logic [15:0] cell_word;
  } rsp_word_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_EXEC,
    OP_FILL,
    OP_SCROLL,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_clear;
    logic need_scroll;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/tcw_ctrl.sv */
// Sequencer for the text console writer.
// Depends on tcw_pkg for the datapath command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire tcw_pkg::dp_status_t status,
  output logic                    ready,
  output tcw_pkg::dp_cmd_t        cmd
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   if (status.sweep_last) state_next = ST_IDLE;
      ST_IDLE:   if (cmd_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (status.is_read)          state_next = ST_DONE;
        else if (status.is_clear)    state_next = ST_CLEAR;
        else if (status.need_scroll) state_next = ST_SCROLL;
        else                         state_next = ST_DONE;
      end
      ST_CLEAR:  if (status.sweep_last) state_next = ST_DONE;
      ST_SCROLL: if (status.sweep_last) state_next = ST_DONE;
      ST_DONE:   if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      ready <= 1'b0;
    end else begin
      state <= state_next;
      ready <= (state_next == ST_IDLE);
    end
  end

  always_comb begin
    cmd.load = cmd_valid && ready;
    unique case (state)
      ST_INIT, ST_CLEAR: cmd.op = OP_FILL;
      ST_EXEC:           cmd.op = OP_EXEC;
      ST_SCROLL:         cmd.op = OP_SCROLL;
      ST_DONE:           cmd.op = OP_EMIT;
      default:           cmd.op = OP_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/tcw_datapath.sv */
// Datapath: screen memory, cursor, attribute, sweep counter and response register.
// Depends on tcw_pkg for word layouts and command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tcw_pkg::dp_cmd_t    cmd,
  input  wire tcw_pkg::cmd_word_t  cmd_word,
  output tcw_pkg::dp_status_t      status,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output tcw_pkg::rsp_word_t       rsp_word
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] SWEEP_END = AW'(CELLS - 1);

  cmd_word_t       item;
  logic [CW-1:0]   col;
  logic [RW-1:0]   row;
  logic [7:0]      attr;
  logic            esc;
  logic [AW-1:0]   cnt;

  logic [15:0]     mem [CELLS];
  logic [15:0]     rd_data;
  logic            pend_we;
  logic            pend_from_rd;
  logic [AW-1:0]   pend_addr;
  logic [15:0]     pend_data;

  function automatic logic [AW-1:0] cell_pos(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(COLUMNS) + AW'(c);
  endfunction

  // put decode
  logic          is_put;
  logic          is_clear;
  logic          do_write;
  logic [7:0]    wr_char;
  logic [CW-1:0] wr_col;
  logic [CW:0]   col_ext;
  logic [CW:0]   col_step;
  logic          row_step;
  logic          wrap;
  logic [CW-1:0] col_fin;
  logic [RW:0]   row_adv;
  logic          need_scroll;
  logic [RW-1:0] row_fin;

  assign is_put  = (item.action == ACT_PUT);
  assign col_ext = {1'b0, col};
  assign wr_col  = (item.char_byte == BYTE_BS && col != '0) ? col - 1'b1 : col;

  always_comb begin
    col_step = col_ext;
    row_step = 1'b0;
    do_write = 1'b0;
    wr_char  = BYTE_SPACE;
    is_clear = 1'b0;
    if (is_put && !esc) begin
      unique case (item.char_byte)
        BYTE_ESC: ;
        BYTE_FF:  is_clear = 1'b1;
        BYTE_BS: begin
          col_step = {1'b0, wr_col};
          do_write = 1'b1;
        end
        BYTE_TAB: col_step = (col_ext | (CW+1)'(3)) + 1'b1;
        BYTE_CR:  col_step = '0;
        BYTE_LF: begin
          col_step = '0;
          row_step = 1'b1;
        end
        default: begin
          if (item.char_byte >= BYTE_SPACE && item.char_byte <= BYTE_LAST) begin
            do_write = 1'b1;
            wr_char  = item.char_byte;
            col_step = col_ext + 1'b1;
          end
        end
      endcase
    end
  end

  assign wrap        = (col_step >= (CW+1)'(COLUMNS));
  assign col_fin     = wrap ? '0 : col_step[CW-1:0];
  assign row_adv     = {1'b0, row} + (RW+1)'(row_step || wrap);
  assign need_scroll = (row_adv >= (RW+1)'(ROWS));
  assign row_fin     = need_scroll ? RW'(ROWS - 1) : row_adv[RW-1:0];

  // read side
  logic          in_range;
  logic [AW-1:0] read_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          copying;
  logic          emit;
  logic [15:0]   blank;
  logic [15:0]   wr_word;

  assign in_range  = (32'(item.cell_index) < CELLS);
  assign read_addr = in_range ? AW'(item.cell_index) : '0;
  assign copying   = (cnt < COPY_END);
  assign rd_addr   = (cmd.op == OP_SCROLL) ? AW'(cnt + AW'(COLUMNS)) : read_addr;
  assign rd_en     = (cmd.op == OP_EXEC && !is_put) || (cmd.op == OP_SCROLL && copying);
  assign blank     = {attr, BYTE_SPACE};
  assign wr_word   = pend_from_rd ? rd_data : pend_data;

  assign status.is_read     = !is_put;
  assign status.is_clear    = is_clear;
  assign status.need_scroll = need_scroll;
  assign status.sweep_last  = (cnt == SWEEP_END);
  assign status.out_free    = !rsp_valid || rsp_ready;
  assign emit               = (cmd.op == OP_EMIT) && status.out_free;

  // screen store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (pend_we) mem[pend_addr] <= wr_word;
    if (rd_en)   rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= cmd_word;
    if (cmd.op == OP_EXEC) begin
      pend_from_rd <= 1'b0;
      pend_addr    <= cell_pos(row, wr_col);
      pend_data    <= {attr, wr_char};
    end else begin
      pend_from_rd <= (cmd.op == OP_SCROLL) && copying;
      pend_addr    <= cnt;
      pend_data    <= blank;
    end
    if (emit) begin
      rsp_word.cursor_index <= 11'(cell_pos(row, col));
      rsp_word.cell_word    <= (!is_put && in_range) ? rd_data : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      attr      <= RESET_ATTR;
      esc       <= 1'b0;
      cnt       <= '0;
      pend_we   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_EXEC: begin
          pend_we <= do_write;
          if (is_put) begin
            if (esc) begin
              attr <= item.char_byte;
              esc  <= 1'b0;
            end else if (item.char_byte == BYTE_ESC) begin
              esc <= 1'b1;
            end
            col <= col_fin;
            row <= row_fin;
          end
        end
        OP_FILL, OP_SCROLL: begin
          pend_we <= 1'b1;
          cnt     <= status.sweep_last ? '0 : cnt + 1'b1;
        end
        default: pend_we <= 1'b0;
      endcase
      if (emit)           rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/text_console_writer_core.sv */
// Text console writer: ROWS x COLUMNS screen of attribute/character cells.
// Put and read words pass through accept, execute and emit; the response registers
// when emit finds the response register free, and cmd_ready rises with it.
// Form feed and a scroll sweep all ROWS*COLUMNS cells through the screen memory's
// single write port. After reset a clearing pass over all ROWS*COLUMNS cells
// fills the screen with 0x0F20 while cmd_ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire tcw_pkg::cmd_word_t cmd_word,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output tcw_pkg::rsp_word_t      rsp_word
);
  import tcw_pkg::*;

  dp_cmd_t    ctrl_cmd;
  dp_status_t dp_status;

  // Sequencer: reset clear, per-word execute, clear/scroll sweeps, response
  // hand-off. The response register in the datapath lets a finished word wait
  // for rsp_ready while the sequencer returns to idle.
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .status    (dp_status),
    .ready     (cmd_ready),
    .cmd       (ctrl_cmd)
  );

  // Datapath: screen memory (registered read), cursor/attribute/escape state,
  // sweep counter shared by reset clear, clear and scroll. Scroll copies row r+1 to row r
  // one cell a cycle through a one-deep write stage, then blanks the bottom row.
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctrl_cmd),
    .cmd_word  (cmd_word),
    .status    (dp_status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

  // an accepted word goes straight to execute and blocks further words
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> (ctrl_cmd.op == OP_EXEC) && !cmd_ready)
    else $error("accepted word did not enter execute");

  // no word is taken while the memory is being swept
  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    (ctrl_cmd.op == OP_FILL || ctrl_cmd.op == OP_SCROLL) |-> !cmd_ready)
    else $error("command accepted during a sweep");

  // the response register is loaded when the sequencer hands off
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (ctrl_cmd.op == OP_EMIT && dp_status.out_free) |=> rsp_valid)
    else $error("response lost at hand-off");

endmodule

`default_nettype wire
